// ----- rtl/sevmb_pkg.sv -----
`default_nettype none

package sevmb_pkg;

  // Pipeline depth: stage 1 (input capture) through stage 6 (output register)
  localparam int unsigned N_STAGES = 6;

  localparam logic [31:0] VALUE_B_MUL = 32'h9e3779b9;
  localparam logic [31:0] STEP_MUL    = 32'h85ebca6b;
  localparam logic [31:0] HASH_MUL1   = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL2   = 32'h846ca68b;

  localparam logic [6:0] AMOUNT_FULL = 7'd100;
  localparam logic [6:0] PCT_ROUND   = 7'd50;

  // Rounded mix sum: 16b * 100 + 16b * 100 bound + 50 stays below 2^23
  localparam int unsigned MIX_W = 23;
  // floor(x / 100) = (x * DIV100_RECIP) >> DIV100_SHIFT, exact for x < 2^23
  localparam logic [23:0] DIV100_RECIP = 24'd10737419;
  localparam int unsigned DIV100_SHIFT = 30;

  // 32-bit word mod 100 folded bytewise: 2^8, 2^16, 2^24 mod 100 = 56, 36, 16
  localparam int unsigned FOLD_W = 15;
  localparam logic [FOLD_W-1:0] FOLD_W1 = 15'd56;
  localparam logic [FOLD_W-1:0] FOLD_W2 = 15'd36;
  localparam logic [FOLD_W-1:0] FOLD_W3 = 15'd16;
  localparam logic [FOLD_W-1:0] FOLD_HUNDRED = 15'd100;
  // floor(s / 100) = (s * FOLD_RECIP) >> FOLD_SHIFT, exact for s < 2^15
  localparam logic [FOLD_W-1:0] FOLD_RECIP = 15'd20972;
  localparam int unsigned FOLD_SHIFT = 21;

  typedef enum logic [1:0] {
    MODE_ALL,
    MODE_PITCH,
    MODE_RHYTHM,
    MODE_VELOCITY
  } mode_t;

  typedef enum logic [1:0] {
    REG_AMOUNT,
    REG_MODE,
    REG_BASE_SCENE,
    REG_TARGET_SCENE
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] amount;
    mode_t      mode;
    logic [7:0] base_scene;
    logic [7:0] target_scene;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  step_number;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [7:0]  note_a;
    logic [7:0]  note_b;
    logic [7:0]  velocity_a;
    logic [7:0]  velocity_b;
    logic [15:0] duration_a;
    logic [15:0] duration_b;
    logic [15:0] gate_a;
    logic [15:0] gate_b;
    logic [3:0]  flag_bits;
  } event_t;

  typedef struct packed {
    logic [31:0] out_value;
    logic [7:0]  out_note;
    logic [7:0]  out_velocity;
    logic [15:0] out_duration;
    logic [15:0] out_gate;
    logic        out_active;
    logic        out_accent;
    logic [7:0]  out_step;
    logic        took_whole_b;
  } result_t;

  typedef struct packed {
    event_t     ev;
    logic [6:0] amount;
    mode_t      mode;
  } pipe_t;

endpackage

`default_nettype wire

// ----- rtl/sevmb_cfg.sv -----
`default_nettype none

module sevmb_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  sevmb_pkg::reg_idx_t idx,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output sevmb_pkg::cfg_t   cfg
);
  import sevmb_pkg::*;

  logic wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amount       <= '0;
      cfg.mode         <= MODE_ALL;
      cfg.base_scene   <= '0;
      cfg.target_scene <= 8'd1;
    end else if (wr) begin
      case (idx)
        REG_AMOUNT: begin
          // out-of-range amounts are dropped
          if (pwdata[6:0] <= AMOUNT_FULL) cfg.amount <= pwdata[6:0];
        end
        REG_MODE:         cfg.mode         <= mode_t'(pwdata[1:0]);
        REG_BASE_SCENE:   cfg.base_scene   <= pwdata[7:0];
        REG_TARGET_SCENE: cfg.target_scene <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AMOUNT:       prdata = {25'd0, cfg.amount};
      REG_MODE:         prdata = {30'd0, cfg.mode};
      REG_BASE_SCENE:   prdata = {24'd0, cfg.base_scene};
      REG_TARGET_SCENE: prdata = {24'd0, cfg.target_scene};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sevmb_hash.sv -----
`default_nettype none

// Selector hash, five stages: seed mix, two multiply rounds, byte fold, mod 100.
module sevmb_hash (
  input  logic              clk,
  input  logic [4:0]        en,
  input  sevmb_pkg::event_t ev,
  input  sevmb_pkg::cfg_t   cfg,
  output logic [6:0]        sel
);
  import sevmb_pkg::*;

  logic [31:0] x1;
  logic [31:0] x2;
  logic [31:0] x4;
  logic [FOLD_W-1:0] fold;

  logic [63:0] prod_b;
  logic [39:0] prod_s;
  logic [31:0] seed;
  logic [31:0] x1_next;
  logic [63:0] prod_h1;
  logic [31:0] x3;
  logic [63:0] prod_h2;
  logic [31:0] x5;
  logic [FOLD_W-1:0] fold_next;
  logic [2*FOLD_W-1:0] quo_prod;
  logic [8:0] quo;
  logic [FOLD_W-1:0] rem_wide;

  always_comb begin
    prod_b  = 64'(ev.value_b) * 64'(VALUE_B_MUL);
    prod_s  = 40'(ev.step_number) * 40'(STEP_MUL);
    seed    = ev.value_a ^ prod_b[31:0] ^ prod_s[31:0]
              ^ {16'd0, cfg.base_scene, 8'd0} ^ {24'd0, cfg.target_scene};
    x1_next = seed ^ (seed >> 16);

    prod_h1 = 64'(x2 ^ (x2 >> 15)) * 64'(HASH_MUL2);
    x3      = prod_h1[31:0];

    x5        = x4 ^ (x4 >> 16);
    fold_next = FOLD_W'(x5[7:0]) + FOLD_W'(x5[15:8]) * FOLD_W1
                + FOLD_W'(x5[23:16]) * FOLD_W2 + FOLD_W'(x5[31:24]) * FOLD_W3;

    quo_prod = (2*FOLD_W)'(fold) * (2*FOLD_W)'(FOLD_RECIP);
    quo      = quo_prod[FOLD_SHIFT +: 9];
    rem_wide = fold - FOLD_W'(quo) * FOLD_HUNDRED;

    prod_h2 = 64'(x1) * 64'(HASH_MUL1);
  end

  always_ff @(posedge clk) begin
    if (en[0]) x1   <= x1_next;
    if (en[1]) x2   <= prod_h2[31:0];
    if (en[2]) x4   <= x3;
    if (en[3]) fold <= fold_next;
    if (en[4]) sel  <= rem_wide[6:0];
  end

endmodule

`default_nettype wire

// ----- rtl/sevmb_mix.sv -----
`default_nettype none

// Rounded percentage blend (a*(100-m) + b*m + 50) / 100 over two stages.
module sevmb_mix (
  input  logic        clk,
  input  logic        en_sum,
  input  logic        en_div,
  input  logic [15:0] a,
  input  logic [15:0] b,
  input  logic [6:0]  amount,
  output logic [15:0] mix
);
  import sevmb_pkg::*;

  logic [MIX_W-1:0] sum;
  logic [MIX_W-1:0] sum_next;
  logic [MIX_W+23:0] quo_prod;

  always_comb begin
    sum_next = MIX_W'(a) * MIX_W'(AMOUNT_FULL - amount)
               + MIX_W'(b) * MIX_W'(amount) + MIX_W'(PCT_ROUND);
    quo_prod = (MIX_W+24)'(sum) * (MIX_W+24)'(DIV100_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en_sum) sum <= sum_next;
    if (en_div) mix <= quo_prod[DIV100_SHIFT +: 16];
  end

endmodule

`default_nettype wire

// ----- rtl/sequence_event_morph_blend_core.sv -----
// Event morph blend core.
// Input channel (event_valid / event_stall / event_data) carries one A/B event
// pair with its step index; output channel (blend_valid / blend_stall /
// blend_data) carries the blended event. A transaction completes on a clock
// edge with valid high and stall low. Morph amount, mode and both scene
// numbers come from the APB-style register port (byte addresses 0, 4, 8, 12);
// change them only while no transaction is in flight.
// Six register stages: capture, two hash multiply rounds, byte fold plus mix
// sums, mod-100 plus divide by 100, output register. blend_valid rises when
// the transaction reaches the output register; throughput is one transaction
// per cycle while blend_stall stays low, set by the fully pipelined hash and
// mix lanes.
// Each stage advances whenever it is empty or the next one advances, so a
// stall on the output fills bubbles first and only then raises event_stall;
// nothing is dropped or duplicated. Synchronous reset empties the pipeline and
// loads amount 0, mode all, base scene 0, morph scene 1.
`default_nettype none

module sequence_event_morph_blend_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               event_valid,
  output logic               event_stall,
  input  sevmb_pkg::event_t  event_data,
  output logic               blend_valid,
  input  logic               blend_stall,
  output sevmb_pkg::result_t blend_data
);
  import sevmb_pkg::*;

  cfg_t cfg;

  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] en;
  pipe_t p [N_STAGES-1];

  logic [6:0]  sel;
  logic [15:0] mix_note;
  logic [15:0] mix_vel;
  logic [15:0] mix_dur;
  logic [15:0] mix_gate;

  result_t res_next;
  logic    take_flags;

  assign pready = 1'b1;

  sevmb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .idx     (reg_idx_t'(paddr[3:2])),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // stage enables ripple back from the output register
  always_comb begin
    en[N_STAGES-1] = !vld[N_STAGES-1] || !blend_stall;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign event_stall = !en[0];
  assign blend_valid = vld[N_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= event_valid;
      for (int i = 1; i < N_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p[0].ev     <= event_data;
      p[0].amount <= cfg.amount;
      p[0].mode   <= cfg.mode;
    end
    for (int i = 1; i < N_STAGES - 1; i++) begin
      if (en[i]) p[i] <= p[i-1];
    end
  end

  sevmb_hash u_hash (
    .clk (clk),
    .en  (en[4:0]),
    .ev  (event_data),
    .cfg (cfg),
    .sel (sel)
  );

  sevmb_mix u_mix_note (
    .clk    (clk),
    .en_sum (en[3]),
    .en_div (en[4]),
    .a      ({8'd0, p[2].ev.note_a}),
    .b      ({8'd0, p[2].ev.note_b}),
    .amount (p[2].amount),
    .mix    (mix_note)
  );

  sevmb_mix u_mix_vel (
    .clk    (clk),
    .en_sum (en[3]),
    .en_div (en[4]),
    .a      ({8'd0, p[2].ev.velocity_a}),
    .b      ({8'd0, p[2].ev.velocity_b}),
    .amount (p[2].amount),
    .mix    (mix_vel)
  );

  sevmb_mix u_mix_dur (
    .clk    (clk),
    .en_sum (en[3]),
    .en_div (en[4]),
    .a      (p[2].ev.duration_a),
    .b      (p[2].ev.duration_b),
    .amount (p[2].amount),
    .mix    (mix_dur)
  );

  sevmb_mix u_mix_gate (
    .clk    (clk),
    .en_sum (en[3]),
    .en_div (en[4]),
    .a      (p[2].ev.gate_a),
    .b      (p[2].ev.gate_b),
    .amount (p[2].amount),
    .mix    (mix_gate)
  );

  always_comb begin
    take_flags = (p[4].amount == AMOUNT_FULL) || (sel < p[4].amount);

    res_next.out_value    = p[4].ev.value_a;
    res_next.out_note     = p[4].ev.note_a;
    res_next.out_velocity = p[4].ev.velocity_a;
    res_next.out_duration = p[4].ev.duration_a;
    res_next.out_gate     = p[4].ev.gate_a;
    res_next.out_active   = p[4].ev.flag_bits[0];
    res_next.out_accent   = p[4].ev.flag_bits[1];
    res_next.out_step     = p[4].ev.step_number;
    res_next.took_whole_b = 1'b0;

    if (p[4].amount != '0) begin
      case (p[4].mode)
        MODE_ALL: begin
          if (p[4].amount == AMOUNT_FULL) begin
            res_next.took_whole_b = 1'b1;
            res_next.out_value    = p[4].ev.value_b;
            res_next.out_note     = p[4].ev.note_b;
            res_next.out_velocity = p[4].ev.velocity_b;
            res_next.out_duration = p[4].ev.duration_b;
            res_next.out_gate     = p[4].ev.gate_b;
            res_next.out_active   = p[4].ev.flag_bits[2];
            res_next.out_accent   = p[4].ev.flag_bits[3];
          end else begin
            res_next.out_note     = mix_note[7:0];
            res_next.out_velocity = mix_vel[7:0];
            res_next.out_duration = mix_dur;
            res_next.out_gate     = mix_gate;
            if (take_flags) begin
              res_next.out_active = p[4].ev.flag_bits[2];
              res_next.out_accent = p[4].ev.flag_bits[3];
            end
          end
        end
        MODE_PITCH: begin
          res_next.out_note = mix_note[7:0];
        end
        MODE_RHYTHM: begin
          res_next.out_duration = mix_dur;
          res_next.out_gate     = mix_gate;
          if (take_flags) begin
            res_next.out_active = p[4].ev.flag_bits[2];
            res_next.out_accent = p[4].ev.flag_bits[3];
          end
        end
        default: begin
          res_next.out_velocity = mix_vel[7:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[N_STAGES-1]) blend_data <= res_next;
  end

  // full pipeline behind a stalled output must push back on the input
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (blend_valid && blend_stall && (&vld)) |-> event_stall)
    else $error("input not stalled with pipeline full and output stalled");

  // an empty output register lets every stage move
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[N_STAGES-1] |-> !event_stall)
    else $error("input stalled while output stage empty");

  // a delivered result with nothing behind it leaves the output empty
  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    (blend_valid && !blend_stall && !vld[N_STAGES-2]) |=> !blend_valid)
    else $error("result appeared without a transaction behind it");

endmodule

`default_nettype wire
